[design/tfr_pkg.sv]
package tfr_pkg;

   // Field types shared by the channel interfaces and the receiver
   typedef logic [7:0]  rx_byte_type;
   typedef logic [15:0] coord_type;
   typedef logic [31:0] ms_type;
   typedef logic [31:0] count_type;

   // Frame layout
   localparam rx_byte_type HDR_FIRST  = 8'h2C;
   localparam rx_byte_type HDR_SECOND = 8'h12;
   localparam rx_byte_type TAIL_BYTE  = 8'h5B;
   localparam int          FRAME_LEN  = 7;

   // Position of the tail byte and of the first payload byte in the frame
   localparam logic [2:0] TAIL_POS     = 3'(FRAME_LEN - 1);
   localparam logic [2:0] PAYLOAD_POS  = 3'd2;

   // Reset value of the center register
   localparam coord_type CENTER_RESET = 16'd320;

endpackage

[design/tfr_channel_if.sv]
interface tfr_req_if
   import tfr_pkg::*;
();
   logic        valid;
   logic        ready;
   rx_byte_type rx_byte;
   ms_type      now_ms;

   modport source (output valid, output rx_byte, output now_ms, input ready);
   modport sink   (input valid, input rx_byte, input now_ms, output ready);
endinterface

interface tfr_rsp_if
   import tfr_pkg::*;
();
   logic               valid;
   logic               ready;
   coord_type          x_coord;
   coord_type          y_coord;
   logic signed [15:0] x_offset;
   ms_type             rx_time_ms;
   count_type          frame_number;

   modport source (output valid, output x_coord, output y_coord, output x_offset,
                   output rx_time_ms, output frame_number, input ready);
   modport sink   (input valid, input x_coord, input y_coord, input x_offset,
                   input rx_time_ms, input frame_number, output ready);
endinterface

[design/target_frame_receiver.sv]
// Channel   Direction  Role
// req_bus   in         received byte and its millisecond time
// rsp_bus   out        X, Y, X offset, tail time and frame number of a good frame
// csr_*     in         write of the X center register
//
// One byte per cycle while the result is not stalled: a byte passes an input
// register, the frame parser and offset subtract, then the result register.
// Synchronous reset clears the parser, the frame counter and both valid
// flags and loads the center with 320. A stalled result holds the parser;
// one more byte waits in the input register.
module target_frame_receiver
   import tfr_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   tfr_req_if.sink         req_bus,
   tfr_rsp_if.source       rsp_bus,
   input  logic            csr_wr_en,
   input  coord_type       csr_wr_data
);

   localparam logic [1:0] PHASE_HUNT    = 2'd0;
   localparam logic [1:0] PHASE_HEADER  = 2'd1;
   localparam logic [1:0] PHASE_COLLECT = 2'd2;

   coord_type          center_ff;

   logic               in_valid_ff;
   rx_byte_type        in_byte_ff;
   ms_type             in_time_ff;

   logic [1:0]         phase_ff, phase_in;
   logic [2:0]         index_ff, index_in;
   rx_byte_type        payload_ff [4];
   count_type          count_ff, count_in;

   logic               rsp_valid_ff, rsp_valid_in;
   coord_type          x_coord_ff, y_coord_ff;
   logic signed [15:0] x_offset_ff;
   ms_type             rx_time_ff;
   count_type          frame_number_ff;

   logic               advance;
   logic               process;
   logic               emit;
   logic               store_en;
   logic [1:0]         store_sel;
   coord_type          x_value;
   coord_type          y_value;
   coord_type          offset_value;

   // Parser moves when the result register is free or being drained
   assign advance       = !rsp_valid_ff || rsp_bus.ready;
   assign process       = in_valid_ff && advance;
   assign req_bus.ready = !in_valid_ff || advance;

   // Center register
   always_ff @(posedge clock) begin
      if (reset) begin
         center_ff <= CENTER_RESET;
      end else if (csr_wr_en) begin
         center_ff <= csr_wr_data;
      end
   end

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_bus.ready) begin
         in_valid_ff <= req_bus.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_bus.valid && req_bus.ready) begin
         in_byte_ff <= req_bus.rx_byte;
         in_time_ff <= req_bus.now_ms;
      end
   end

   // Assemble the coordinates and the centered X
   assign x_value      = {payload_ff[0], payload_ff[1]};
   assign y_value      = {payload_ff[2], payload_ff[3]};
   assign offset_value = (x_value != '0) ? coord_type'(x_value - center_ff) : '0;

   // Frame parser
   always_comb begin
      phase_in  = phase_ff;
      index_in  = index_ff;
      count_in  = count_ff;
      emit      = 1'b0;
      store_en  = 1'b0;
      store_sel = 2'(index_ff - PAYLOAD_POS);
      if (process) begin
         unique case (phase_ff)
            PHASE_HUNT: begin
               if (in_byte_ff == HDR_FIRST) begin
                  phase_in = PHASE_HEADER;
                  index_in = 3'd1;
               end
            end
            PHASE_HEADER: begin
               priority if (in_byte_ff == HDR_SECOND) begin
                  phase_in = PHASE_COLLECT;
                  index_in = PAYLOAD_POS;
               end else if (in_byte_ff == HDR_FIRST) begin
                  phase_in = PHASE_HEADER;
                  index_in = 3'd1;
               end else begin
                  phase_in = PHASE_HUNT;
                  index_in = 3'd0;
               end
            end
            default: begin
               // collecting; the unused phase code behaves the same
               if (index_ff < TAIL_POS) begin
                  store_en = (index_ff >= PAYLOAD_POS);
                  index_in = index_ff + 3'd1;
               end else begin
                  if (in_byte_ff == TAIL_BYTE) begin
                     emit     = 1'b1;
                     count_in = count_ff + 32'd1;
                  end
                  if (in_byte_ff == HDR_FIRST) begin
                     phase_in = PHASE_HEADER;
                     index_in = 3'd1;
                  end else begin
                     phase_in = PHASE_HUNT;
                     index_in = 3'd0;
                  end
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PHASE_HUNT;
         index_ff <= 3'd0;
         count_ff <= '0;
      end else begin
         phase_ff <= phase_in;
         index_ff <= index_in;
         count_ff <= count_in;
      end
   end

   // Payload bytes
   always_ff @(posedge clock) begin
      if (store_en) begin
         payload_ff[store_sel] <= in_byte_ff;
      end
   end

   // Result register: load on a good tail, drop once taken
   assign rsp_valid_in = advance ? emit : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         x_coord_ff      <= x_value;
         y_coord_ff      <= y_value;
         x_offset_ff     <= signed'(offset_value);
         rx_time_ff      <= in_time_ff;
         frame_number_ff <= count_in;
      end
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.x_coord      = x_coord_ff;
   assign rsp_bus.y_coord      = y_coord_ff;
   assign rsp_bus.x_offset     = x_offset_ff;
   assign rsp_bus.rx_time_ms   = rx_time_ff;
   assign rsp_bus.frame_number = frame_number_ff;

endmodule

[design/tfr_check.sv]
module tfr_check
   import tfr_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_wr_en,
   input  coord_type          csr_wr_data,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  coord_type          x_coord,
   input  logic signed [15:0] x_offset,
   input  count_type          frame_number
);

   coord_type center_ff;

   // Track the center as written on the port
   always_ff @(posedge clock) begin
      if (reset) begin
         center_ff <= CENTER_RESET;
      end else if (csr_wr_en) begin
         center_ff <= csr_wr_data;
      end
   end

   // No transaction is offered right after reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // A zero X gives a zero offset
   a_zero_offset: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && x_coord == '0) |-> (x_offset == '0))
      else $error("nonzero offset for zero X");

   // A nonzero X gives X minus the center
   a_offset: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && x_coord != '0) |-> (coord_type'(x_offset) == coord_type'(x_coord - center_ff)))
      else $error("offset does not match center");

   // A stalled transaction keeps its frame number
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(frame_number)))
      else $error("stalled result changed");

endmodule

bind target_frame_receiver tfr_check u_tfr_check (
   .clock        (clock),
   .reset        (reset),
   .csr_wr_en    (csr_wr_en),
   .csr_wr_data  (csr_wr_data),
   .rsp_valid    (rsp_bus.valid),
   .rsp_ready    (rsp_bus.ready),
   .x_coord      (rsp_bus.x_coord),
   .x_offset     (rsp_bus.x_offset),
   .frame_number (rsp_bus.frame_number)
);
